// File: rtl/core/hff_pkg.sv
`timescale 1ns / 1ps

package hff_pkg;

	localparam int FracW = 24;
	localparam int LzW   = 5;
	localparam int BexpW = 10;

	localparam logic [6:0] ExpDenormLo = 7'd27;
	localparam logic [6:0] ExpDenormHi = 7'd32;
	localparam logic [8:0] DenormShiftBase = 9'd130;
	localparam logic signed [BexpW-1:0] Rebias = 10'sd130;
	localparam logic signed [BexpW-1:0] BexpMax = 10'sd254;
	localparam logic signed [BexpW-1:0] BexpMin = 10'sd1;

	typedef enum logic [1:0] {
		KIND_ZERO   = 2'd0,
		KIND_UNDER  = 2'd1,
		KIND_DENORM = 2'd2,
		KIND_NORMAL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	typedef struct packed {
		logic             sign;
		kind_t            kind;
		logic [6:0]       expo;
		logic [FracW-1:0] frac;
		logic [LzW-1:0]   lz;
		logic [LzW-1:0]   rsh_m1;
	} dec_t;

	typedef struct packed {
		logic                    sign;
		kind_t                   kind;
		logic signed [BexpW-1:0] bexp;
		logic [FracW-1:0]        mant;
		logic                    rnd;
	} aln_t;

	typedef struct packed {
		logic [31:0] word;
		status_t     status;
	} res_t;

endpackage

// File: rtl/core/hff_decode.sv
`timescale 1ns / 1ps

module hff_decode (
	input  logic                clk,
	input  logic                en,
	input  logic [31:0]         word,
	output hff_pkg::dec_t       dec_s1
);

	hff_pkg::dec_t  dec_d;
	logic [8:0]     rsh_full;

	always_comb begin
		dec_d.sign = word[31];
		dec_d.expo = word[30:24];
		dec_d.frac = word[23:0];
		dec_d.lz   = '0;
		for (int i = 0; i < hff_pkg::FracW; i++) begin
			if (word[i]) begin
				dec_d.lz = hff_pkg::LzW'(hff_pkg::FracW - 1 - i);
			end
		end
		rsh_full = hff_pkg::DenormShiftBase - {word[30:24], 2'b00};
		dec_d.rsh_m1 = rsh_full[hff_pkg::LzW-1:0];
		if (word[23:0] == '0) begin
			dec_d.kind = hff_pkg::KIND_ZERO;
		end else if (word[30:24] <= hff_pkg::ExpDenormHi) begin
			if (word[30:24] < hff_pkg::ExpDenormLo) begin
				dec_d.kind = hff_pkg::KIND_UNDER;
			end else begin
				dec_d.kind = hff_pkg::KIND_DENORM;
			end
		end else begin
			dec_d.kind = hff_pkg::KIND_NORMAL;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= dec_d;
		end
	end

endmodule

// File: rtl/core/hff_align.sv
`timescale 1ns / 1ps

module hff_align (
	input  logic                clk,
	input  logic                en,
	input  hff_pkg::dec_t       dec,
	output hff_pkg::aln_t       aln_s2
);

	hff_pkg::aln_t               aln_d;
	logic [hff_pkg::FracW-1:0]   lsh;
	logic [hff_pkg::FracW-1:0]   rsh;

	always_comb begin
		lsh = dec.frac << dec.lz;
		rsh = dec.frac >> dec.rsh_m1;
		aln_d.sign = dec.sign;
		aln_d.kind = dec.kind;
		aln_d.bexp = $signed({1'b0, dec.expo, 2'b00}) - hff_pkg::Rebias
			- $signed({{(hff_pkg::BexpW-hff_pkg::LzW){1'b0}}, dec.lz});
		if (dec.kind == hff_pkg::KIND_DENORM) begin
			aln_d.mant = {1'b0, rsh[hff_pkg::FracW-1:1]};
			aln_d.rnd  = rsh[0];
		end else begin
			aln_d.mant = {1'b0, lsh[hff_pkg::FracW-2:0]};
			aln_d.rnd  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aln_s2 <= aln_d;
		end
	end

endmodule

// File: rtl/core/hff_pack.sv
`timescale 1ns / 1ps

module hff_pack (
	input  logic                clk,
	input  logic                en,
	input  hff_pkg::aln_t       aln,
	output hff_pkg::res_t       res_s3
);

	hff_pkg::res_t res_d;

	always_comb begin
		res_d.word   = '0;
		res_d.status = hff_pkg::ST_OK;
		unique case (aln.kind)
			hff_pkg::KIND_ZERO: begin
				res_d.word = '0;
			end
			hff_pkg::KIND_UNDER: begin
				res_d.status = hff_pkg::ST_UNDER;
			end
			hff_pkg::KIND_DENORM: begin
				res_d.word = {aln.sign, 31'b0} + {8'b0, aln.mant} + {31'b0, aln.rnd};
			end
			hff_pkg::KIND_NORMAL: begin
				if (aln.bexp < hff_pkg::BexpMin) begin
					res_d.status = hff_pkg::ST_UNDER;
				end else if (aln.bexp > hff_pkg::BexpMax) begin
					res_d.status = hff_pkg::ST_OVER;
				end else begin
					res_d.word = {aln.sign, aln.bexp[7:0], aln.mant[22:0]};
				end
			end
			default: begin
				res_d.word = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_d;
		end
	end

endmodule

// File: rtl/core/hex_float_to_binary_float.sv
`timescale 1ns / 1ps
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// hex in   | hex_valid, hex_stall  | hex_float_word[31:0]
// bin out  | bin_valid, bin_stall  | binary_float_word[31:0], conversion_status[1:0]
//
// three register stages: decode and leading-zero count, shift, round and pack
// one word per cycle while bin_stall is low; bin_valid is the pack stage valid bit
// arst_n clears the stage valid bits only, payload registers are not reset
// a stall on the output holds the last stage and backs up stage by stage,
// empty stages keep filling until the pipe is full, then hex_stall rises

module hex_float_to_binary_float (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hex_valid,
	output logic        hex_stall,
	input  logic [31:0] hex_float_word,
	output logic        bin_valid,
	input  logic        bin_stall,
	output logic [31:0] binary_float_word,
	output logic [1:0]  conversion_status
);

	hff_pkg::dec_t dec_s1;
	hff_pkg::aln_t aln_s2;
	hff_pkg::res_t res_s3;
	logic          v_s1;
	logic          v_s2;
	logic          v_s3;
	logic          adv1;
	logic          adv2;
	logic          adv3;

	assign adv3      = !v_s3 || !bin_stall;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign hex_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= hex_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	hff_decode u_decode (
		.clk    (clk),
		.en     (adv1),
		.word   (hex_float_word),
		.dec_s1 (dec_s1)
	);

	hff_align u_align (
		.clk    (clk),
		.en     (adv2),
		.dec    (dec_s1),
		.aln_s2 (aln_s2)
	);

	hff_pack u_pack (
		.clk    (clk),
		.en     (adv3),
		.aln    (aln_s2),
		.res_s3 (res_s3)
	);

	assign bin_valid         = v_s3;
	assign binary_float_word = res_s3.word;
	assign conversion_status = res_s3.status;

	a_err_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid && (conversion_status != hff_pkg::ST_OK) |-> binary_float_word == 32'd0)
		else $error("error status with nonzero word");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid |-> (conversion_status == hff_pkg::ST_OK)
			|| (conversion_status == hff_pkg::ST_UNDER)
			|| (conversion_status == hff_pkg::ST_OVER))
		else $error("undefined status code");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		hex_valid && !hex_stall |=> v_s1)
		else $error("accepted word not captured");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && bin_stall |-> hex_stall)
		else $error("full pipeline took a word");

endmodule

// File: tb/hex_float_to_binary_float_test.sv
`timescale 1ns / 1ps

module hex_float_to_binary_float_test;
	import hff_pkg::*;

	localparam int StallLimit = 2000;
	localparam int HoldCycles = 80;

	typedef struct {
		logic [31:0] hex;
		res_t        res;
	} pending_t;

	logic        clk;
	logic        arst_n;
	logic        hex_valid;
	logic        hex_stall;
	logic [31:0] hex_float_word;
	logic        bin_valid;
	logic        bin_stall;
	logic [31:0] binary_float_word;
	logic [1:0]  conversion_status;

	pending_t pending_q[$];
	int       sender_idle_pct;
	int       receiver_stall_pct;
	bit       hold_req;
	int       fail_count;
	int       quiet_cycles;

	hex_float_to_binary_float dut (
		.clk(clk),
		.arst_n(arst_n),
		.hex_valid(hex_valid),
		.hex_stall(hex_stall),
		.hex_float_word(hex_float_word),
		.bin_valid(bin_valid),
		.bin_stall(bin_stall),
		.binary_float_word(binary_float_word),
		.conversion_status(conversion_status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic res_t convert_hex_float(logic [31:0] w);
		logic        sgn;
		int          e;
		logic [23:0] f;
		logic [23:0] m;
		int          z;
		int          s;
		int          be;
		res_t        r;
		sgn = w[31];
		e = int'(w[30:24]);
		f = w[23:0];
		r.word = '0;
		r.status = ST_OK;
		if (f == '0) begin
			r.word = '0;
		end else if (e <= int'(ExpDenormHi)) begin
			if (e < int'(ExpDenormLo)) begin
				r.status = ST_UNDER;
			end else begin
				// denormal, round half up, any carry goes into the exponent
				s = 131 - 4 * e;
				r.word = {sgn, 31'(f >> s)} + 32'(f[s-1]);
			end
		end else begin
			z = 0;
			while (z < 24 && !f[23-z])
				z++;
			be = 4 * e - 130 - z;
			if (be < 1) begin
				r.status = ST_UNDER;
			end else if (be > 254) begin
				r.status = ST_OVER;
			end else begin
				m = f << z;
				r.word = {sgn, be[7:0], m[22:0]};
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] random_hex_word();
		logic [6:0]  e;
		logic [23:0] f;
		case ($urandom_range(9))
			0: return $urandom;
			1: e = 7'($urandom_range(26));
			2: e = 7'($urandom_range(32, 27));
			3, 4, 5: e = 7'($urandom_range(96, 33));
			6: e = 7'($urandom_range(127, 97));
			7: e = 7'($urandom_range(40, 33));
			8: e = 7'($urandom_range(100, 90));
			default: e = 7'($urandom);
		endcase
		case ($urandom_range(5))
			0: f = '0;
			1: f = 24'(1) << $urandom_range(23);
			2, 3: f = 24'($urandom);
			default: f = 24'($urandom) >> $urandom_range(23);
		endcase
		return {1'($urandom), e, f};
	endfunction

	// receiver side: random stall, or a long hold when asked
	initial begin
		bin_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HoldCycles) begin
					bin_stall <= 1'b1;
					@(negedge clk);
				end
			end
			bin_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// predict on input accept, check on output accept, watchdog
	always @(posedge clk) begin
		pending_t p;
		if (arst_n) begin
			if (hex_valid && !hex_stall) begin
				p.hex = hex_float_word;
				p.res = convert_hex_float(hex_float_word);
				pending_q.push_back(p);
			end
			if (bin_valid && !bin_stall) begin
				if (pending_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected word %h status %0d",
							binary_float_word, conversion_status);
				end else begin
					p = pending_q.pop_front();
					if (p.res.word !== binary_float_word ||
						p.res.status !== conversion_status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("in %h: expected word %h status %0d, got word %h status %0d",
								p.hex, p.res.word, p.res.status,
								binary_float_word, conversion_status);
					end
				end
			end
			if ((hex_valid && !hex_stall) || (bin_valid && !bin_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		if (quiet_cycles >= StallLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_hex_word(input logic [31:0] w);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			hex_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		hex_valid <= 1'b1;
		hex_float_word <= w;
		@(posedge clk);
		while (hex_stall)
			@(posedge clk);
	endtask

	task automatic test_directed();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		// zeros, with and without exponent
		send_hex_word(32'h00000000);
		send_hex_word(32'h80000000);
		send_hex_word(32'h41000000);
		send_hex_word(32'hFF000000);
		// exponent too small
		send_hex_word(32'h00000001);
		send_hex_word(32'h9AFFFFFF);
		// denormal range and its rounding
		send_hex_word(32'h1B400000);
		send_hex_word(32'h1B3FFFFF);
		send_hex_word(32'h9B3FFFFF);
		send_hex_word(32'h1BFFFFFF);
		send_hex_word(32'h20FFFFFF);
		send_hex_word(32'hA0000004);
		send_hex_word(32'h20000003);
		// normal range near the bottom and in the middle
		send_hex_word(32'h21800000);
		send_hex_word(32'h21400000);
		send_hex_word(32'h21200000);
		send_hex_word(32'h41100000);
		send_hex_word(32'hC1000001);
		// normal range near the top
		send_hex_word(32'h60800000);
		send_hex_word(32'h61800000);
		send_hex_word(32'h61000001);
		send_hex_word(32'h7FFFFFFF);
		send_hex_word(32'hFFFFFFFF);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int n_words);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (n_words)
			send_hex_word(random_hex_word());
	endtask

	task automatic test_long_output_stall();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_req = 1'b1;
		repeat (60)
			send_hex_word(random_hex_word());
	endtask

	initial begin
		arst_n = 1'b0;
		hex_valid = 1'b0;
		hex_float_word = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_req = 1'b0;
		fail_count = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_traffic(0, 0, 500);
		test_random_traffic(70, 0, 350);
		test_random_traffic(0, 70, 350);
		test_long_output_stall();
		test_random_traffic(29, 29, 300);

		@(negedge clk);
		hex_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
